// ----- rtl/trbd_pkg.sv -----
// ----------------------------------------------------------------------------
// trbd_pkg
// Shared types and codes for the radix text decoder: modes, commands,
// result kinds, status codes and the decoded-request entry.
// ----------------------------------------------------------------------------
package trbd_pkg;

  localparam int POSITION_BITS = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_HEX         = 2'd0,
    MODE_BIN         = 2'd1,
    MODE_B64         = 2'd2,
    MODE_ALL_INVALID = 2'd3
  } trbd_mode_t;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_INVALID    = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  // One entry holds every result caused by one request: up to three bytes,
  // and, when has_status is set, a status result in the last slot.
  typedef struct packed {
    logic [1:0]               nres;
    logic                     has_status;
    logic [1:0]               status;
    logic [POSITION_BITS-1:0] pos;
    logic [7:0]               b0;
    logic [7:0]               b1;
    logic [7:0]               b2;
  } trbd_entry_t;

endpackage

// ----- rtl/trbd_front.sv -----
// ----------------------------------------------------------------------------
// trbd_front
// Classifies each character, updates the group accumulator, phase and
// position count, and builds one queue entry for the results it causes.
// ----------------------------------------------------------------------------
module trbd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mode_wr_en,
  input  logic [1:0]           mode_wr_data,
  input  logic                 req_valid,
  input  logic                 cmd,
  input  logic [7:0]           char_code,
  output logic                 ent_push,
  output trbd_pkg::trbd_entry_t ent
);
  import trbd_pkg::*;

  logic [1:0]               mode;
  logic [23:0]              acc;
  logic [2:0]               phase;
  logic [POSITION_BITS-1:0] count;
  logic                     stopped;

  logic [23:0]              acc_next;
  logic [2:0]               phase_next;
  logic [POSITION_BITS-1:0] count_next;
  logic                     stopped_next;

  logic       is_white, hex_ok, bin_ok, b64_ok, is_pad;
  logic [3:0] hex_val;
  logic [5:0] b64_val;
  logic [23:0] acc_hex, acc_bin, acc_b64;
  logic [7:0] bit_mask;
  logic [1:0] nflush;
  logic [7:0] fb0, fb1;
  logic       incomplete;
  logic       char_ok;

  // Character classes.
  always_comb begin
    is_white = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
    hex_ok   = 1'b1;
    hex_val  = 4'd0;
    if (char_code >= "0" && char_code <= "9") begin
      hex_val = 4'(char_code - "0");
    end else if (char_code >= "A" && char_code <= "F") begin
      hex_val = 4'(char_code - "A" + 8'd10);
    end else if (char_code >= "a" && char_code <= "f") begin
      hex_val = 4'(char_code - "a" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    bin_ok = (char_code == "0") || (char_code == "1");
    is_pad = (char_code == "=");
    b64_ok  = 1'b1;
    b64_val = 6'd0;
    if (char_code >= "A" && char_code <= "Z") begin
      b64_val = 6'(char_code - "A");
    end else if (char_code >= "a" && char_code <= "z") begin
      b64_val = 6'(char_code - "a" + 8'd26);
    end else if (char_code >= "0" && char_code <= "9") begin
      b64_val = 6'(char_code - "0" + 8'd52);
    end else if (char_code == "+") begin
      b64_val = 6'd62;
    end else if (char_code == "/") begin
      b64_val = 6'd63;
    end else begin
      b64_ok = 1'b0;
    end
  end

  // Accumulator candidates, base64 partial-group flush, incomplete flag, char check.
  always_comb begin
    acc_hex  = {acc[19:0], hex_val};
    bit_mask = 8'h80 >> phase;
    acc_bin  = (char_code == "1") ? (acc | {16'd0, bit_mask}) : acc;
    acc_b64  = {acc[17:0], b64_val};
    nflush   = 2'd0;
    fb0      = acc[11:4];
    fb1      = 8'd0;
    if (mode == MODE_B64) begin
      if (phase == 3'd2) begin
        nflush = 2'd1;
      end else if (phase >= 3'd3) begin
        nflush = 2'd2;
        fb0    = acc[17:10];
        fb1    = acc[9:2];
      end
    end
    if (mode == MODE_B64) begin
      incomplete = (phase == 3'd1);
    end else if (mode == MODE_ALL_INVALID) begin
      incomplete = 1'b0;
    end else begin
      incomplete = (phase != 3'd0);
    end
    char_ok = (mode == MODE_HEX && hex_ok) || (mode == MODE_BIN && bin_ok) ||
              (mode == MODE_B64 && (b64_ok || is_pad));
  end

  always_comb begin
    acc_next     = acc;
    phase_next   = phase;
    count_next   = count;
    stopped_next = stopped;
    ent          = '0;
    if (cmd == CMD_END) begin
      if (!stopped) begin
        ent.nres = nflush;
        ent.b0   = fb0;
        ent.b1   = fb1;
      end
      ent.nres       = ent.nres + 2'd1;
      ent.has_status = 1'b1;
      if (incomplete) begin
        ent.status = STATUS_INCOMPLETE;
        ent.pos    = (count != '0) ? count - 1'b1 : count;
      end else begin
        ent.status = stopped ? STATUS_INVALID : STATUS_OK;
        ent.pos    = count;
      end
      acc_next     = '0;
      phase_next   = '0;
      count_next   = '0;
      stopped_next = 1'b0;
    end else if (!stopped) begin
      if (char_ok || (mode != MODE_ALL_INVALID && is_white)) begin
        if (count != '1) begin
          count_next = count + 1'b1;
        end
      end
      if (char_ok) begin
        unique case (mode)
          MODE_HEX: begin
            if (phase != 3'd0) begin
              ent.nres   = 2'd1;
              ent.b0     = acc_hex[7:0];
              acc_next   = '0;
              phase_next = '0;
            end else begin
              acc_next   = acc_hex;
              phase_next = 3'd1;
            end
          end
          MODE_BIN: begin
            if (phase == 3'd7) begin
              ent.nres   = 2'd1;
              ent.b0     = acc_bin[7:0];
              acc_next   = '0;
              phase_next = '0;
            end else begin
              acc_next   = acc_bin;
              phase_next = phase + 3'd1;
            end
          end
          MODE_B64: begin
            if (!is_pad) begin
              acc_next = acc_b64;
              if (phase >= 3'd3) begin
                ent.nres   = 2'd3;
                ent.b0     = acc_b64[23:16];
                ent.b1     = acc_b64[15:8];
                ent.b2     = acc_b64[7:0];
                phase_next = '0;
              end else begin
                phase_next = phase + 3'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end else if (!(mode != MODE_ALL_INVALID && is_white)) begin
        // Invalid character: freeze the position and flush a base64 partial group.
        stopped_next = 1'b1;
        ent.nres     = nflush;
        ent.b0       = fb0;
        ent.b1       = fb1;
      end
    end
  end

  assign ent_push = req_valid && (ent.nres != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_HEX;
      acc     <= '0;
      phase   <= '0;
      count   <= '0;
      stopped <= 1'b0;
    end else begin
      if (mode_wr_en) begin
        mode <= mode_wr_data;
      end
      if (req_valid) begin
        acc     <= acc_next;
        phase   <= phase_next;
        count   <= count_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule

// ----- rtl/trbd_queue.sv -----
// ----------------------------------------------------------------------------
// trbd_queue
// Short queue of decoded entries between the front and the back part.
// ----------------------------------------------------------------------------
module trbd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  trbd_pkg::trbd_entry_t wr_data,
  input  logic                  rd_en,
  output trbd_pkg::trbd_entry_t rd_data,
  output logic                  q_full,
  output logic                  q_empty
);
  import trbd_pkg::*;

  trbd_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign q_full  = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/trbd_back.sv -----
// ----------------------------------------------------------------------------
// trbd_back
// Walks the head entry of the queue and presents its results one by one.
// ----------------------------------------------------------------------------
module trbd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  trbd_pkg::trbd_entry_t      head,
  input  logic                       head_valid,
  output logic                       head_done,
  input  logic                       pop,
  output logic                       kind,
  output logic [7:0]                 data_byte,
  output logic [1:0]                 status_code,
  output logic [trbd_pkg::POSITION_BITS-1:0] stop_position,
  output logic                       last
);
  import trbd_pkg::*;

  logic [1:0] slot;
  logic [7:0] byte_sel;

  always_comb begin
    unique case (slot)
      2'd0:    byte_sel = head.b0;
      2'd1:    byte_sel = head.b1;
      default: byte_sel = head.b2;
    endcase
    last = (slot == head.nres - 2'd1);
    // The status result, when present, is always the last slot of an entry.
    kind          = (head.has_status && last) ? KIND_STATUS : KIND_DATA;
    data_byte     = (kind == KIND_DATA) ? byte_sel : 8'd0;
    status_code   = (kind == KIND_STATUS) ? head.status : STATUS_OK;
    stop_position = (kind == KIND_STATUS) ? head.pos : '0;
  end

  assign head_done = pop && head_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (pop && head_valid) begin
      slot <= last ? 2'd0 : slot + 2'd1;
    end
  end

endmodule

// ----- rtl/text_radix_to_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// text_radix_to_byte_decoder
// Decodes hexadecimal, binary or base64 text to bytes, ending each text
// with one status result.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  input     push / full                    cmd, char_code
//  result    empty / pop                    kind, data_byte, status_code,
//                                           stop_position, last
//  config    encoding_mode_wr_en            encoding_mode
//
// The front takes one request per cycle while the four-entry queue has room;
// one request yields up to three results, and the back delivers one result
// per cycle while pop is held, so the result count per request sets the rate.
// Each request's results are registered in the queue and reach the ports from its head.
// Reset clears the mode to hexadecimal, the decode state and the queue.
// A stalled result side fills the queue and then raises full.
// ----------------------------------------------------------------------------
module text_radix_to_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        encoding_mode_wr_en,
  input  logic [1:0]  encoding_mode,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  char_code,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [1:0]  status_code,
  output logic [trbd_pkg::POSITION_BITS-1:0] stop_position,
  output logic        last
);
  import trbd_pkg::*;

  trbd_entry_t ent;
  trbd_entry_t head;
  logic        ent_push;
  logic        head_done;
  logic        q_full;
  logic        q_empty;
  logic        req_valid;

  assign full      = q_full;
  assign empty     = q_empty;
  assign req_valid = push && !q_full;

  trbd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .mode_wr_en   (encoding_mode_wr_en),
    .mode_wr_data (encoding_mode),
    .req_valid    (req_valid),
    .cmd          (cmd),
    .char_code    (char_code),
    .ent_push     (ent_push),
    .ent          (ent)
  );

  trbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ent_push),
    .wr_data (ent),
    .rd_en   (head_done),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  trbd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (!q_empty),
    .head_done     (head_done),
    .pop           (pop),
    .kind          (kind),
    .data_byte     (data_byte),
    .status_code   (status_code),
    .stop_position (stop_position),
    .last          (last)
  );

endmodule

// ----- sim/text_radix_to_byte_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// text_radix_to_byte_decoder_tb
// Self-checking bench for the radix text decoder. Texts are sent in hex,
// binary, base64 and the all-invalid mode, and every result is checked
// against a predictor that tracks the decode state request by request.
// Both queue sides stall at random; one long result stall fills the block.
// ----------------------------------------------------------------------------
module text_radix_to_byte_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trbd_pkg::*;

  localparam int          CYCLE_LIMIT      = 1000000;
  localparam int          RANDOM_ITEMS     = 48;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          SETTLE_CYCLES    = 4;
  localparam logic [7:0]  CHAR_PAD         = 8'h3D;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               data_byte;
    logic [1:0]               status;
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     mode_wr_en = 1'b0;
  logic [1:0]               mode_wr_data = 2'd0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     cmd = CMD_CHAR;
  logic [7:0]               char_code = 8'h00;
  logic                     empty;
  logic                     pop = 1'b0;
  logic                     kind;
  logic [7:0]               data_byte;
  logic [1:0]               status_code;
  logic [POSITION_BITS-1:0] stop_position;
  logic                     last;

  // Decoder state as the predictor sees it.
  logic [1:0]               mode_q = MODE_HEX;
  logic [23:0]              acc = '0;
  logic [2:0]               phase = '0;
  logic [POSITION_BITS-1:0] char_count = '0;
  logic                     halted = 1'b0;

  result_t due_results[$];
  int      errors = 0;
  int      sent_requests = 0;
  int      checked_results = 0;
  int      texts_done = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;
  bit      hold_results = 1'b0;

  string   hex_digits = "0123456789abcdefABCDEF";
  string   b64_symbols =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  text_radix_to_byte_decoder u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .encoding_mode_wr_en (mode_wr_en),
    .encoding_mode       (mode_wr_data),
    .push                (push),
    .full                (full),
    .cmd                 (cmd),
    .char_code           (char_code),
    .empty               (empty),
    .pop                 (pop),
    .kind                (kind),
    .data_byte           (data_byte),
    .status_code         (status_code),
    .stop_position       (stop_position),
    .last                (last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still due", cycle_count,
             due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int hex_digit(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    return -1;
  endfunction

  function automatic int b64_symbol(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch - "A");
    if (ch >= "a" && ch <= "z") return int'(ch - "a") + 26;
    if (ch >= "0" && ch <= "9") return int'(ch - "0") + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    return -1;
  endfunction

  function automatic logic is_blank(logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic result_t make_result(logic k, logic [7:0] b, logic [1:0] st,
                                          logic [POSITION_BITS-1:0] p);
    result_t r;
    r.kind      = k;
    r.data_byte = b;
    r.status    = st;
    r.pos       = p;
    r.last      = 1'b0;
    return r;
  endfunction

  // A base64 group cut short by a stop or the end of text still yields
  // the bytes that its symbols fully cover.
  task automatic flush_b64(ref result_t batch[$]);
    if (mode_q == MODE_B64) begin
      if (phase == 3'd2) begin
        batch.push_back(make_result(KIND_DATA, acc[11:4], STATUS_OK, '0));
      end else if (phase >= 3'd3) begin
        batch.push_back(make_result(KIND_DATA, acc[17:10], STATUS_OK, '0));
        batch.push_back(make_result(KIND_DATA, acc[9:2], STATUS_OK, '0));
      end
    end
  endtask

  task automatic decode_request(input logic req_cmd, input logic [7:0] ch);
    result_t                  batch[$];
    int                       hv;
    int                       bv;
    logic [POSITION_BITS-1:0] pos;
    logic [1:0]               st;
    logic                     incomplete;
    logic                     counts;
    counts = 1'b0;
    if (req_cmd == CMD_END) begin
      pos = char_count;
      if (!halted) flush_b64(batch);
      if (mode_q == MODE_B64) incomplete = (phase == 3'd1);
      else if (mode_q == MODE_ALL_INVALID) incomplete = 1'b0;
      else incomplete = (phase != 3'd0);
      if (incomplete) begin
        st = STATUS_INCOMPLETE;
        if (pos != 0) pos = pos - 1'b1;
      end else begin
        st = halted ? STATUS_INVALID : STATUS_OK;
      end
      batch.push_back(make_result(KIND_STATUS, 8'h00, st, pos));
      acc        = '0;
      phase      = '0;
      char_count = '0;
      halted     = 1'b0;
    end else if (!halted) begin
      hv     = hex_digit(ch);
      bv     = b64_symbol(ch);
      counts = 1'b1;
      if (mode_q == MODE_HEX && hv >= 0) begin
        acc = {acc[19:0], hv[3:0]};
        if (phase != 3'd0) begin
          batch.push_back(make_result(KIND_DATA, acc[7:0], STATUS_OK, '0));
          acc   = '0;
          phase = '0;
        end else begin
          phase = 3'd1;
        end
      end else if (mode_q == MODE_BIN && (ch == "0" || ch == "1")) begin
        if (ch == "1") acc = acc | (24'h80 >> phase);
        if (phase >= 3'd7) begin
          batch.push_back(make_result(KIND_DATA, acc[7:0], STATUS_OK, '0));
          acc   = '0;
          phase = '0;
        end else begin
          phase = phase + 1'b1;
        end
      end else if (mode_q == MODE_B64 && (ch == CHAR_PAD || bv >= 0)) begin
        // Padding is counted as a character but adds no bits.
        if (ch != CHAR_PAD) begin
          acc = {acc[17:0], bv[5:0]};
          if (phase >= 3'd3) begin
            batch.push_back(make_result(KIND_DATA, acc[23:16], STATUS_OK, '0));
            batch.push_back(make_result(KIND_DATA, acc[15:8], STATUS_OK, '0));
            batch.push_back(make_result(KIND_DATA, acc[7:0], STATUS_OK, '0));
            phase = '0;
          end else begin
            phase = phase + 1'b1;
          end
        end
      end else if (mode_q == MODE_ALL_INVALID || !is_blank(ch)) begin
        halted = 1'b1;
        counts = 1'b0;
        flush_b64(batch);
      end
      if (counts && char_count != POS_MAX) char_count = char_count + 1'b1;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  function automatic int draw_gap();
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] pick_char(logic [1:0] m);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 8'($urandom_range(0, 255));
    if (roll < 9) begin
      roll = $urandom_range(0, 5);
      return (roll == 5) ? 8'h20 : 8'h09 + 8'(roll);
    end
    unique case (m)
      MODE_HEX: return hex_digits[$urandom_range(0, 21)];
      MODE_BIN: return $urandom_range(0, 1) ? "1" : "0";
      default:  return b64_symbols[$urandom_range(0, 64)];
    endcase
  endfunction

  task automatic send_request(input logic req_cmd, input logic [7:0] ch);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    cmd       <= req_cmd;
    char_code <= ch;
    do @(posedge clk); while (full !== 1'b0);
    decode_request(req_cmd, ch);
    sent_requests++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_request(CMD_CHAR, s[i]);
  endtask

  task automatic end_text();
    send_request(CMD_END, 8'($urandom_range(0, 255)));
    texts_done++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // Blank characters cause no result, so let the pipeline settle too.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain_results();
    mode_wr_en   <= 1'b1;
    mode_wr_data <= m;
    @(posedge clk);
    mode_q = m;
    mode_wr_en <= 1'b0;
  endtask

  task automatic test_hex_text();
    set_mode(MODE_HEX);
    send_chars("Af 0");
    end_text();
    send_chars("3c");
    send_request(CMD_CHAR, 8'hFF);
    end_text();
    end_text();
  endtask

  task automatic test_binary_text();
    set_mode(MODE_BIN);
    send_chars("1000 0001");
    end_text();
    send_chars("1");
    send_request(CMD_CHAR, 8'h00);
    end_text();
  endtask

  task automatic test_base64_text();
    set_mode(MODE_B64);
    send_chars("//+9zA=");
    end_text();
    send_chars("QUJ*");
    end_text();
    send_chars("Q");
    end_text();
  endtask

  task automatic test_all_invalid_mode();
    set_mode(MODE_ALL_INVALID);
    send_chars(" ");
    end_text();
    end_text();
  endtask

  // The digit phase carries across a mode change inside one text.
  task automatic test_mode_switch_in_text();
    set_mode(MODE_HEX);
    send_chars("5");
    set_mode(MODE_B64);
    send_chars("QQ");
    end_text();
    send_chars("AB");
    set_mode(MODE_BIN);
    send_chars("101010");
    end_text();
  endtask

  task automatic test_queue_backpressure();
    set_mode(MODE_B64);
    idle_on      = 1'b0;
    hold_results = 1'b1;
    send_chars("////////////////////AAAA");
    send_chars("QU");
    drain_results();
    send_chars("JD");
    end_text();
    idle_on = 1'b1;
  endtask

  task automatic test_random_texts();
    int         counted;
    int         len;
    logic [1:0] m;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      m = ($urandom_range(0, 9) == 0) ? MODE_ALL_INVALID : 2'($urandom_range(0, 2));
      set_mode(m);
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && $urandom_range(0, 7) == 0) set_mode(2'($urandom_range(0, 2)));
        counted++;
        send_request(CMD_CHAR, pick_char(mode_q));
      end
      counted++;
      end_text();
    end
    idle_on = 1'b1;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin : result_sink
    result_t want;
    int      gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d byte 0x%0h status %0d pos %0d",
               kind, data_byte, status_code, stop_position);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
        check_field("status_code", 16'(want.status), 16'(status_code));
        check_field("stop_position", 16'(want.pos), 16'(stop_position));
        check_field("last", 16'(want.last), 16'(last));
        checked_results++;
      end
    end
  end

  initial begin : main_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hex_text();
    test_binary_text();
    test_base64_text();
    test_all_invalid_mode();
    test_mode_switch_in_text();
    test_queue_backpressure();
    test_random_texts();
    drain_results();
    $display("Sent %0d requests in %0d texts in hex, binary, base64 and all-invalid modes,",
             sent_requests, texts_done);
    $display("with mode changes inside texts and a full queue; %0d results checked.",
             checked_results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- text_radix_to_byte_decoder.f -----
rtl/trbd_pkg.sv
rtl/trbd_front.sv
rtl/trbd_queue.sv
rtl/trbd_back.sv
rtl/text_radix_to_byte_decoder.sv
sim/text_radix_to_byte_decoder_tb.sv
